>>> hdl/fbpm_pkg.sv
package fbpm_pkg;

    // Fixed geometry of the pool manager
    localparam int NPOOL        = 4;
    localparam int POOL_COUNT   = 4;
    localparam int HEADER_BYTES = 5;
    localparam int MAX_PER_POOL = 256;

    localparam int COUNT_W   = 9;
    localparam int BYTES_W   = 13;
    localparam int SLOT_W    = 8;
    localparam int OFF_W     = 12;
    localparam int LINK_W    = 9;
    localparam int PID_W     = 3;
    localparam int PIDX_W    = 2;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = COUNT_W + BYTES_W;
    localparam int VPROD_W   = SLOT_W + BYTES_W;

    // Stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 5;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    // Null link / pointer
    localparam logic [LINK_W-1:0] LINK_NIL = 9'h100;

    localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd16;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [BYTES_W-1:0] bytes_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_INSERT = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_BAD   = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_A_COUNT = 3'd0,
        CFG_POOL_A_BYTES = 3'd1,
        CFG_POOL_B_COUNT = 3'd2,
        CFG_POOL_B_BYTES = 3'd3,
        CFG_POOL_C_COUNT = 3'd4,
        CFG_POOL_C_BYTES = 3'd5,
        CFG_POOL_D_COUNT = 3'd6,
        CFG_POOL_D_BYTES = 3'd7
    } cfg_idx_t;

    // Link memory port controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } link_ctl_t;

endpackage

>>> hdl/fixed_block_buffer_pool_manager_core.sv
// A result passes from the request through the EVAL and FIN states into the output
// register; a stalled result holds the engine until it is taken.
// Each request is a registered link read or the first link write, then the link write-back
// that closes the list update; the next request is taken as the previous one leaves FIN.
// A configuration write recomputes the pool layout, a multiply then a check per pool; no request
// is accepted meanwhile. Reset: all pools absent, all lists empty, link memory not cleared.
module fixed_block_buffer_pool_manager_core #(
    parameter int REGION_BYTES = 4096,
    parameter int SLOTS_TOTAL  = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // slave side
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [fbpm_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [7:0] buffer_slot
    input  logic [fbpm_pkg::IN_TUSER_W-1:0]        s_axis_tuser,  // [1:0] operation, [4:2] pool_id
    // master side
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [fbpm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [7:0] result_slot,
                                                                  // [19:8] byte_offset, zero pad
    output logic [fbpm_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                                   cfg_we,
    input  logic [fbpm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fbpm_pkg::BYTES_W-1:0]           cfg_wdata
);
    import fbpm_pkg::*;

    localparam int BYTE_W      = $clog2(REGION_BYTES + 1);
    localparam int SLOT_BASE_W = $clog2(SLOTS_TOTAL + 1);
    localparam int ADDR_W      = $clog2(SLOTS_TOTAL);

    count_t [NPOOL-1:0] pool_count_reg, pool_count_next;
    bytes_t [NPOOL-1:0] pool_bytes_reg, pool_bytes_next;

    logic                               lay_busy;
    logic [NPOOL-1:0]                   lay_ok;
    logic [NPOOL-1:0][BYTE_W-1:0]       lay_base_byte;
    logic [NPOOL-1:0][SLOT_BASE_W-1:0]  lay_base_slot;

    link_ctl_t                          link_ctl;
    logic [ADDR_W-1:0]                  link_waddr;
    logic [ADDR_W-1:0]                  link_raddr;
    logic [LINK_W-1:0]                  link_wdata;
    logic [LINK_W-1:0]                  link_rdata;

    logic [STAT_W-1:0]                  res_status;
    logic [SLOT_W-1:0]                  res_slot;
    logic [OFF_W-1:0]                   res_offset;

    // Configuration register file
    always_comb
    begin
        pool_count_next = pool_count_reg;
        pool_bytes_next = pool_bytes_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_POOL_A_COUNT: pool_count_next[0] = cfg_wdata[COUNT_W-1:0];
                CFG_POOL_A_BYTES: pool_bytes_next[0] = cfg_wdata;
                CFG_POOL_B_COUNT: pool_count_next[1] = cfg_wdata[COUNT_W-1:0];
                CFG_POOL_B_BYTES: pool_bytes_next[1] = cfg_wdata;
                CFG_POOL_C_COUNT: pool_count_next[2] = cfg_wdata[COUNT_W-1:0];
                CFG_POOL_C_BYTES: pool_bytes_next[2] = cfg_wdata;
                CFG_POOL_D_COUNT: pool_count_next[3] = cfg_wdata[COUNT_W-1:0];
                CFG_POOL_D_BYTES: pool_bytes_next[3] = cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPOOL; i++)
            begin
                pool_count_reg[i] <= '0;
                pool_bytes_reg[i] <= BYTES_RESET;
            end
        end
        else
        begin
            pool_count_reg <= pool_count_next;
            pool_bytes_reg <= pool_bytes_next;
        end
    end

    // Pool layout, recomputed after every configuration write
    fbpm_layout #(
        .REGION_BYTES (REGION_BYTES),
        .SLOTS_TOTAL  (SLOTS_TOTAL)
    ) u_layout (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (cfg_we),
        .pool_count    (pool_count_reg),
        .pool_bytes    (pool_bytes_reg),
        .busy          (lay_busy),
        .lay_ok        (lay_ok),
        .lay_base_byte (lay_base_byte),
        .lay_base_slot (lay_base_slot)
    );

    // Next-link store
    fbpm_link_mem #(
        .SLOTS_TOTAL (SLOTS_TOTAL)
    ) u_link_mem (
        .clk   (clk),
        .ctl   (link_ctl),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Request sequencer and list pointers
    fbpm_engine #(
        .REGION_BYTES (REGION_BYTES),
        .SLOTS_TOTAL  (SLOTS_TOTAL)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .list_clear    (cfg_we),
        .lay_busy      (lay_busy),
        .lay_ok        (lay_ok),
        .lay_base_byte (lay_base_byte),
        .lay_base_slot (lay_base_slot),
        .pool_count    (pool_count_reg),
        .pool_bytes    (pool_bytes_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_op         (s_axis_tuser[OP_W-1:0]),
        .in_pool       (s_axis_tuser[OP_W+PID_W-1:OP_W]),
        .in_slot       (s_axis_tdata[SLOT_W-1:0]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_status    (res_status),
        .out_slot      (res_slot),
        .out_offset    (res_offset),
        .link_ctl      (link_ctl),
        .link_waddr    (link_waddr),
        .link_wdata    (link_wdata),
        .link_raddr    (link_raddr),
        .link_rdata    (link_rdata)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - SLOT_W - OFF_W){1'b0}}, res_offset, res_slot};
    assign m_axis_tuser = res_status;

endmodule

>>> hdl/fbpm_layout.sv
module fbpm_layout #(
    parameter int REGION_BYTES = 4096,
    parameter int SLOTS_TOTAL  = 256,
    localparam int BYTE_W      = $clog2(REGION_BYTES + 1),
    localparam int SLOT_BASE_W = $clog2(SLOTS_TOTAL + 1)
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  fbpm_pkg::count_t [fbpm_pkg::NPOOL-1:0]     pool_count,
    input  fbpm_pkg::bytes_t [fbpm_pkg::NPOOL-1:0]     pool_bytes,
    output logic                                       busy,
    output logic [fbpm_pkg::NPOOL-1:0]                 lay_ok,
    output logic [fbpm_pkg::NPOOL-1:0][BYTE_W-1:0]     lay_base_byte,
    output logic [fbpm_pkg::NPOOL-1:0][SLOT_BASE_W-1:0] lay_base_slot
);
    import fbpm_pkg::*;

    localparam int SUM_W  = ((BYTE_W > PROD_W) ? BYTE_W : PROD_W) + 1;
    localparam int SCNT_W = ((SLOT_BASE_W > COUNT_W) ? SLOT_BASE_W : COUNT_W) + 1;

    typedef enum logic [2:0] {
        LAY_IDLE = 3'b001,
        LAY_MUL  = 3'b010,
        LAY_CHK  = 3'b100
    } lay_state_t;

    lay_state_t               lay_state_reg, lay_state_next;
    logic [PIDX_W-1:0]        idx_reg, idx_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [BYTE_W-1:0]        byte_acc_reg, byte_acc_next;
    logic [SLOT_BASE_W-1:0]   slot_acc_reg, slot_acc_next;
    logic [NPOOL-1:0]         ok_reg, ok_next;
    logic [NPOOL-1:0][BYTE_W-1:0]      base_byte_reg;
    logic [NPOOL-1:0][SLOT_BASE_W-1:0] base_slot_reg;

    count_t              cur_count;
    bytes_t              cur_bytes;
    logic [SUM_W-1:0]    byte_sum;
    logic [SCNT_W-1:0]   slot_sum;
    logic                fits;
    logic                chk_en;

    assign cur_count = pool_count[idx_reg];
    assign cur_bytes = pool_bytes[idx_reg];
    assign byte_sum  = SUM_W'(byte_acc_reg) + SUM_W'(prod_reg);
    assign slot_sum  = SCNT_W'(slot_acc_reg) + SCNT_W'(cur_count);

    // Pool exists and fits behind the pools before it
    assign fits = (int'(idx_reg) < POOL_COUNT) && (cur_count != '0) &&
                  (cur_count <= COUNT_W'(MAX_PER_POOL)) &&
                  (cur_bytes > BYTES_W'(HEADER_BYTES)) &&
                  (byte_sum <= SUM_W'(REGION_BYTES)) &&
                  (slot_sum <= SCNT_W'(SLOTS_TOTAL));

    assign chk_en = (lay_state_reg == LAY_CHK) && !start;

    // One pool at a time: multiply, then check and accumulate
    always_comb
    begin
        lay_state_next = lay_state_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        byte_acc_next  = byte_acc_reg;
        slot_acc_next  = slot_acc_reg;
        ok_next        = ok_reg;
        if (start)
        begin
            lay_state_next = LAY_MUL;
            idx_next       = '0;
            byte_acc_next  = '0;
            slot_acc_next  = '0;
        end
        else
        begin
            unique case (lay_state_reg)
                LAY_IDLE:
                begin
                end
                LAY_MUL:
                begin
                    prod_next      = PROD_W'(cur_count) * PROD_W'(cur_bytes);
                    lay_state_next = LAY_CHK;
                end
                LAY_CHK:
                begin
                    ok_next[idx_reg] = fits;
                    if (fits)
                    begin
                        byte_acc_next = BYTE_W'(byte_sum);
                        slot_acc_next = SLOT_BASE_W'(slot_sum);
                    end
                    if (idx_reg == PIDX_W'(NPOOL - 1))
                    begin
                        lay_state_next = LAY_IDLE;
                    end
                    else
                    begin
                        idx_next       = idx_reg + PIDX_W'(1);
                        lay_state_next = LAY_MUL;
                    end
                end
                default:
                begin
                    lay_state_next = LAY_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lay_state_reg <= LAY_IDLE;
            idx_reg       <= '0;
            ok_reg        <= '0;
            byte_acc_reg  <= '0;
            slot_acc_reg  <= '0;
        end
        else
        begin
            lay_state_reg <= lay_state_next;
            idx_reg       <= idx_next;
            ok_reg        <= ok_next;
            byte_acc_reg  <= byte_acc_next;
            slot_acc_reg  <= slot_acc_next;
        end
    end

    // Product and base addresses carry no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (chk_en)
        begin
            base_byte_reg[idx_reg] <= byte_acc_reg;
            base_slot_reg[idx_reg] <= slot_acc_reg;
        end
    end

    assign busy          = (lay_state_reg != LAY_IDLE);
    assign lay_ok        = ok_reg;
    assign lay_base_byte = base_byte_reg;
    assign lay_base_slot = base_slot_reg;

endmodule

>>> hdl/fbpm_link_mem.sv
module fbpm_link_mem #(
    parameter int SLOTS_TOTAL = 256,
    localparam int ADDR_W     = $clog2(SLOTS_TOTAL)
) (
    input  logic                          clk,
    input  fbpm_pkg::link_ctl_t           ctl,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [fbpm_pkg::LINK_W-1:0]   wdata,
    input  logic [ADDR_W-1:0]             raddr,
    output logic [fbpm_pkg::LINK_W-1:0]   rdata
);
    import fbpm_pkg::*;

    logic [LINK_W-1:0] link_store [SLOTS_TOTAL];
    logic [LINK_W-1:0] rdata_reg;

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            link_store[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= link_store[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fbpm_engine.sv
module fbpm_engine #(
    parameter int REGION_BYTES = 4096,
    parameter int SLOTS_TOTAL  = 256,
    localparam int BYTE_W      = $clog2(REGION_BYTES + 1),
    localparam int SLOT_BASE_W = $clog2(SLOTS_TOTAL + 1),
    localparam int ADDR_W      = $clog2(SLOTS_TOTAL)
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        list_clear,
    input  logic                                        lay_busy,
    input  logic [fbpm_pkg::NPOOL-1:0]                  lay_ok,
    input  logic [fbpm_pkg::NPOOL-1:0][BYTE_W-1:0]      lay_base_byte,
    input  logic [fbpm_pkg::NPOOL-1:0][SLOT_BASE_W-1:0] lay_base_slot,
    input  fbpm_pkg::count_t [fbpm_pkg::NPOOL-1:0]      pool_count,
    input  fbpm_pkg::bytes_t [fbpm_pkg::NPOOL-1:0]      pool_bytes,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [fbpm_pkg::OP_W-1:0]                   in_op,
    input  logic [fbpm_pkg::PID_W-1:0]                  in_pool,
    input  logic [fbpm_pkg::SLOT_W-1:0]                 in_slot,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [fbpm_pkg::STAT_W-1:0]                 out_status,
    output logic [fbpm_pkg::SLOT_W-1:0]                 out_slot,
    output logic [fbpm_pkg::OFF_W-1:0]                  out_offset,
    output fbpm_pkg::link_ctl_t                         link_ctl,
    output logic [ADDR_W-1:0]                           link_waddr,
    output logic [fbpm_pkg::LINK_W-1:0]                 link_wdata,
    output logic [ADDR_W-1:0]                           link_raddr,
    input  logic [fbpm_pkg::LINK_W-1:0]                 link_rdata
);
    import fbpm_pkg::*;

    localparam int ASUM_W = ((SLOT_BASE_W > SLOT_W) ? SLOT_BASE_W : SLOT_W) + 1;

    typedef enum logic [2:0] {
        ENG_IDLE = 3'b001,
        ENG_EVAL = 3'b010,
        ENG_FIN  = 3'b100
    } eng_state_t;

    eng_state_t               state_reg, state_next;
    op_t                      op_reg;
    logic [PID_W-1:0]         pool_reg;
    logic [SLOT_W-1:0]        slot_reg;
    status_t                  stat_reg;
    logic [SLOT_W-1:0]        v_reg;
    logic [VPROD_W-1:0]       prod_reg;

    logic [NPOOL-1:0][LINK_W-1:0]  free_head_reg, free_head_next;
    logic [NPOOL-1:0][LINK_W-1:0]  free_tail_reg, free_tail_next;
    logic [NPOOL-1:0][LINK_W-1:0]  queue_head_reg, queue_head_next;
    logic [NPOOL-1:0][LINK_W-1:0]  queue_tail_reg, queue_tail_next;
    logic [NPOOL-1:0][COUNT_W-1:0] mark_reg, mark_next;

    logic                     out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]        out_status_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic [OFF_W-1:0]         out_offset_reg;

    logic                     accept;
    logic                     fin_go;
    logic                     id_ok;
    logic [PIDX_W-1:0]        pidx;
    logic                     cur_ok;
    count_t                   cur_c;
    bytes_t                   cur_b;
    logic [SLOT_BASE_W-1:0]   bs;
    logic [BYTE_W-1:0]        bb;
    logic [LINK_W-1:0]        fh, ft, qh, qt;
    logic [COUNT_W-1:0]       mk;
    logic                     slot_in_range;
    logic                     mark_avail;
    logic [LINK_W-1:0]        nxt_link;

    status_t                  eval_stat;
    logic [SLOT_W-1:0]        eval_v;
    logic                     eval_rd;
    logic                     eval_wr;
    logic [SLOT_W-1:0]        eval_off;
    logic                     fin_wr;
    logic [SLOT_W-1:0]        fin_off;
    logic [LINK_W-1:0]        fin_wdata;
    logic [SLOT_W-1:0]        wr_off;
    logic [ASUM_W-1:0]        waddr_sum;
    logic [ASUM_W-1:0]        raddr_sum;

    // Pool lookup for the request in flight
    assign id_ok  = (pool_reg >= PID_W'(1)) && (pool_reg <= PID_W'(NPOOL));
    assign pidx   = PIDX_W'(pool_reg - PID_W'(1));
    assign cur_ok = id_ok && lay_ok[pidx];
    assign cur_c  = pool_count[pidx];
    assign cur_b  = pool_bytes[pidx];
    assign bs     = lay_base_slot[pidx];
    assign bb     = lay_base_byte[pidx];
    assign fh     = free_head_reg[pidx];
    assign ft     = free_tail_reg[pidx];
    assign qh     = queue_head_reg[pidx];
    assign qt     = queue_tail_reg[pidx];
    assign mk     = mark_reg[pidx];

    assign slot_in_range = ({1'b0, slot_reg} < cur_c);
    assign mark_avail    = (mk < cur_c);
    assign nxt_link      = (link_rdata >= cur_c) ? LINK_NIL : link_rdata;

    assign fin_go   = (state_reg == ENG_FIN) && (!out_valid_reg || out_ready);
    assign in_ready = !lay_busy && !list_clear && ((state_reg == ENG_IDLE) || fin_go);
    assign accept   = in_valid && in_ready;

    // EVAL state: pick the slot, start the link read or the first write
    always_comb
    begin
        eval_stat = STAT_BAD;
        eval_v    = '0;
        eval_rd   = 1'b0;
        eval_wr   = 1'b0;
        eval_off  = slot_reg;
        if (cur_ok)
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (mark_avail)
                    begin
                        eval_stat = STAT_OK;
                        eval_v    = mk[SLOT_W-1:0];
                        eval_wr   = 1'b1;
                        eval_off  = mk[SLOT_W-1:0];
                    end
                    else if (fh != LINK_NIL)
                    begin
                        eval_stat = STAT_OK;
                        eval_v    = fh[SLOT_W-1:0];
                        eval_rd   = 1'b1;
                    end
                    else
                    begin
                        eval_stat = STAT_EMPTY;
                    end
                end
                OP_FREE:
                begin
                    if (slot_in_range)
                    begin
                        eval_stat = STAT_OK;
                        eval_wr   = 1'b1;
                        if (mark_avail)
                        begin
                            eval_v = mk[SLOT_W-1:0];
                        end
                        else if (fh == LINK_NIL)
                        begin
                            eval_v = slot_reg;
                        end
                        else
                        begin
                            eval_v = fh[SLOT_W-1:0];
                        end
                    end
                end
                OP_INSERT:
                begin
                    if (slot_in_range)
                    begin
                        eval_stat = STAT_OK;
                        eval_wr   = 1'b1;
                        eval_v    = (qh == LINK_NIL) ? slot_reg : qh[SLOT_W-1:0];
                    end
                end
                OP_GET:
                begin
                    if (qh == LINK_NIL)
                    begin
                        eval_stat = STAT_EMPTY;
                    end
                    else
                    begin
                        eval_stat = STAT_OK;
                        eval_v    = qh[SLOT_W-1:0];
                        eval_rd   = 1'b1;
                    end
                end
                default:
                begin
                    eval_stat = STAT_BAD;
                end
            endcase
        end
    end

    // FIN state: write back the link that closes the operation
    always_comb
    begin
        fin_wr    = 1'b0;
        fin_off   = v_reg;
        fin_wdata = LINK_NIL;
        if (stat_reg == STAT_OK)
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    fin_wr = !mark_avail;
                end
                OP_FREE:
                begin
                    fin_wr    = (fh != LINK_NIL);
                    fin_off   = ft[SLOT_W-1:0];
                    fin_wdata = {1'b0, slot_reg};
                end
                OP_INSERT:
                begin
                    fin_wr    = (qh != LINK_NIL);
                    fin_off   = qt[SLOT_W-1:0];
                    fin_wdata = {1'b0, slot_reg};
                end
                OP_GET:
                begin
                    fin_wr = 1'b1;
                end
                default:
                begin
                    fin_wr = 1'b0;
                end
            endcase
        end
    end

    // Link memory port
    assign wr_off     = (state_reg == ENG_EVAL) ? eval_off : fin_off;
    assign waddr_sum  = ASUM_W'(bs) + ASUM_W'(wr_off);
    assign raddr_sum  = ASUM_W'(bs) + ASUM_W'(eval_v);
    assign link_waddr = waddr_sum[ADDR_W-1:0];
    assign link_raddr = raddr_sum[ADDR_W-1:0];
    assign link_wdata = (state_reg == ENG_EVAL) ? LINK_NIL : fin_wdata;
    assign link_ctl   = '{rd_en: (state_reg == ENG_EVAL) && eval_rd,
                          wr_en: ((state_reg == ENG_EVAL) && eval_wr) || (fin_go && fin_wr)};

    // List pointer updates
    always_comb
    begin
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        queue_head_next = queue_head_reg;
        queue_tail_next = queue_tail_reg;
        mark_next       = mark_reg;
        if (list_clear)
        begin
            for (int i = 0; i < NPOOL; i++)
            begin
                free_head_next[i]  = LINK_NIL;
                free_tail_next[i]  = LINK_NIL;
                queue_head_next[i] = LINK_NIL;
                queue_tail_next[i] = LINK_NIL;
                mark_next[i]       = '0;
            end
        end
        else if (fin_go && (stat_reg == STAT_OK))
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (mark_avail)
                    begin
                        mark_next[pidx] = mk + COUNT_W'(1);
                    end
                    else
                    begin
                        free_head_next[pidx] = nxt_link;
                        if (nxt_link == LINK_NIL)
                        begin
                            free_tail_next[pidx] = LINK_NIL;
                        end
                    end
                end
                OP_FREE:
                begin
                    if (fh == LINK_NIL)
                    begin
                        free_head_next[pidx] = {1'b0, slot_reg};
                    end
                    free_tail_next[pidx] = {1'b0, slot_reg};
                end
                OP_INSERT:
                begin
                    if (qh == LINK_NIL)
                    begin
                        queue_head_next[pidx] = {1'b0, slot_reg};
                    end
                    queue_tail_next[pidx] = {1'b0, slot_reg};
                end
                OP_GET:
                begin
                    queue_head_next[pidx] = nxt_link;
                    if (nxt_link == LINK_NIL)
                    begin
                        queue_tail_next[pidx] = LINK_NIL;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (accept)
                begin
                    state_next = ENG_EVAL;
                end
            end
            ENG_EVAL:
            begin
                state_next = ENG_FIN;
            end
            ENG_FIN:
            begin
                if (fin_go)
                begin
                    state_next = accept ? ENG_EVAL : ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NPOOL; i++)
            begin
                free_head_reg[i]  <= LINK_NIL;
                free_tail_reg[i]  <= LINK_NIL;
                queue_head_reg[i] <= LINK_NIL;
                queue_tail_reg[i] <= LINK_NIL;
                mark_reg[i]       <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            queue_head_reg <= queue_head_next;
            queue_tail_reg <= queue_tail_next;
            mark_reg       <= mark_next;
        end
    end

    // Request, intermediate and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(in_op);
            pool_reg <= in_pool;
            slot_reg <= in_slot;
        end
        if (state_reg == ENG_EVAL)
        begin
            stat_reg <= eval_stat;
            v_reg    <= eval_v;
            prod_reg <= VPROD_W'(eval_v) * VPROD_W'(cur_b);
        end
        if (fin_go)
        begin
            out_status_reg <= stat_reg;
            if (stat_reg == STAT_OK)
            begin
                out_slot_reg   <= v_reg;
                out_offset_reg <= OFF_W'(bb) + OFF_W'(prod_reg);
            end
            else
            begin
                out_slot_reg   <= '0;
                out_offset_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_offset = out_offset_reg;

endmodule

>>> hdl/fbpm_checker.sv
module fbpm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [fbpm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [fbpm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input logic                                cfg_we
);
    import fbpm_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (m_axis_tuser == STAT_OK) || (m_axis_tuser == STAT_BAD) ||
        (m_axis_tuser == STAT_EMPTY))
        else $error("undefined status code");

    // A failed request carries zero slot and offset
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == '0))
        else $error("failed request with nonzero payload");

    // Requests are never accepted back to back
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("requests accepted back to back");

    // Layout recompute blocks requests after a configuration write
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("request accepted during layout recompute");

endmodule

bind fixed_block_buffer_pool_manager_core fbpm_checker u_fbpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we)
);
